// File: hw/rtl/sfax_pkg.sv
// Shared types, constants and the CRC-16 step for the AX.25 UI framer.
// No dependencies; imported by every module of the framer.
`timescale 1ns / 1ps
`default_nettype none
package sfax_pkg;

  localparam int FRAME_BYTES_DEF = 48;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CALL_W          = 48;

  localparam logic [7:0]  SYNC_BYTE = 8'h5D;
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  SSID_DST  = 8'h00;
  localparam logic [7:0]  SSID_SRC  = 8'h60;
  localparam logic [7:0]  CTRL_UI   = 8'h03;
  localparam logic [7:0]  PID_NONE  = 8'hF0;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  localparam logic [CALL_W-1:0] CALL_RESET = 48'h202020202020;

  localparam logic [4:0] HDR_LAST_STEP  = 5'd16;
  localparam logic [4:0] TAIL_LAST_STEP = 5'd2;

  typedef enum logic [1:0] {
    REG_DEST_CALL = 2'd0,
    REG_SRC_CALL  = 2'd1,
    REG_ENABLE    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_HDR  = 2'd0,
    CMD_DATA = 2'd1,
    CMD_TAIL = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } q_entry_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sfax_queue.sv
// Small FIFO of classified commands between the framer front and back.
// Depends on sfax_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module sfax_queue import sfax_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  output logic          full,
  input  wire logic     pop,
  output q_entry_t      head_entry,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign empty      = (count_r == '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sfax_front.sv
// Input side: sync hunt, frame position tracking and command classification.
// Depends on sfax_pkg; feeds sfax_queue.
`timescale 1ns / 1ps
`default_nettype none
module sfax_front import sfax_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       enable,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  output logic            push,
  output q_entry_t        push_entry,
  input  wire logic       q_full
);

  localparam int POS_W = $clog2(FRAME_BYTES);

  logic             in_frame_r, in_frame_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready && enable;

  always_comb begin
    in_frame_nxt    = in_frame_r;
    pos_nxt         = pos_r;
    push            = 1'b0;
    push_entry.kind = CMD_DATA;
    push_entry.data = in_tdata;
    if (accept) begin
      if (!in_frame_r) begin
        if (in_tdata == SYNC_BYTE) begin
          in_frame_nxt    = 1'b1;
          pos_nxt         = POS_W'(1);
          push            = 1'b1;
          push_entry.kind = CMD_HDR;
        end
      end else if (pos_r >= POS_W'(FRAME_BYTES - 1)) begin
        in_frame_nxt    = 1'b0;
        pos_nxt         = '0;
        push            = 1'b1;
        push_entry.kind = CMD_TAIL;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r >= POS_W'(2) && pos_r <= POS_W'(FRAME_BYTES - 3)) begin
          push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sfax_back.sv
// Output side: expands commands into frame bytes, runs the FCS and holds the output item.
// Depends on sfax_pkg; drains sfax_queue.
`timescale 1ns / 1ps
`default_nettype none
module sfax_back import sfax_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CALL_W-1:0] dest_call,
  input  wire logic [CALL_W-1:0] src_call,
  input  wire q_entry_t          head_entry,
  input  wire logic              q_empty,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast
);

  logic [4:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic        emit;
  logic        last_step;
  logic [7:0]  byte_sel;
  logic        last_sel;
  logic [7:0]  hdr_byte;
  logic [2:0]  char_idx;
  logic [7:0]  dest_ch;
  logic [7:0]  src_ch;
  logic [15:0] fcs;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign emit = !q_empty && (!out_valid_r || out_tready);
  assign fcs  = ~crc_r;

  always_comb begin
    char_idx = 3'd0;
    if (step_r >= 5'd8 && step_r <= 5'd13) begin
      char_idx = 3'(step_r - 5'd8);
    end else if (step_r >= 5'd1 && step_r <= 5'd6) begin
      char_idx = 3'(step_r - 5'd1);
    end
    dest_ch = dest_call[CALL_W - 1 - 8 * char_idx -: 8];
    src_ch  = src_call[CALL_W - 1 - 8 * char_idx -: 8];
  end

  always_comb begin
    unique case (step_r) inside
      5'd0:          hdr_byte = FLAG_BYTE;
      [5'd1:5'd6]:   hdr_byte = {dest_ch[6:0], 1'b0};
      5'd7:          hdr_byte = SSID_DST;
      [5'd8:5'd13]:  hdr_byte = {src_ch[6:0], 1'b0};
      5'd14:         hdr_byte = SSID_SRC;
      5'd15:         hdr_byte = CTRL_UI;
      default:       hdr_byte = PID_NONE;
    endcase
  end

  always_comb begin
    byte_sel  = head_entry.data;
    last_sel  = 1'b0;
    last_step = 1'b1;
    crc_nxt   = crc_r;
    unique case (head_entry.kind)
      CMD_HDR: begin
        byte_sel  = hdr_byte;
        last_step = (step_r == HDR_LAST_STEP);
        crc_nxt   = (step_r == 5'd0) ? CRC_INIT : crc_feed(crc_r, hdr_byte);
      end
      CMD_DATA: begin
        crc_nxt = crc_feed(crc_r, head_entry.data);
      end
      CMD_TAIL: begin
        last_step = (step_r == TAIL_LAST_STEP);
        if (step_r == 5'd0) begin
          byte_sel = fcs[7:0];
        end else if (step_r == 5'd1) begin
          byte_sel = fcs[15:8];
        end else begin
          byte_sel = FLAG_BYTE;
          last_sel = 1'b1;
          crc_nxt  = CRC_INIT;
        end
      end
      default: begin
        last_step = 1'b1;
      end
    endcase
  end

  assign pop = emit && last_step;

  always_comb begin
    step_nxt = step_r;
    if (emit) begin
      step_nxt = last_step ? 5'd0 : step_r + 5'd1;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= byte_sel;
      out_last_r <= last_sel;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sync_frame_to_ax25_framer_unit.sv
// Top level of the AX.25 UI framer: configuration registers, front, queue and back.
// Depends on sfax_pkg, sfax_front, sfax_queue and sfax_back.
//
//   Port group   Direction  Content
//   in_*         slave      tdata[7:0] = in_byte
//   out_*        master     tdata[7:0] = out_byte, tlast = frame_last
//   cfg_*        write      addr 0 dest call, 1 src call, 2 enable
//
// The front takes one input item per cycle while the command queue has room.
// The back sends one output item per cycle unless stalled: a sync byte expands
// to 17 header items, each payload byte to one item, and the last frame byte
// to 3 items. A frame of 48 input items therefore yields 64 output items, so
// the output port sets the sustained rate. Reset is synchronous and clears all
// control state; a stalled output holds its item while the queue keeps filling.
`timescale 1ns / 1ps
`default_nettype none
module sync_frame_to_ax25_framer_unit import sfax_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] in_byte
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,  // [7:0] out_byte
  output logic                   out_tlast,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_addr,
  input  wire logic [CALL_W-1:0] cfg_wdata
);

  logic [CALL_W-1:0] dest_call_r;
  logic [CALL_W-1:0] src_call_r;
  logic              enable_r;
  logic              push;
  q_entry_t          push_entry;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  q_entry_t          head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_call_r <= CALL_RESET;
      src_call_r  <= CALL_RESET;
      enable_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEST_CALL: dest_call_r <= cfg_wdata;
        REG_SRC_CALL:  src_call_r  <= cfg_wdata;
        REG_ENABLE:    enable_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  sfax_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .enable     (enable_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  sfax_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_entry (head_entry),
    .empty      (q_empty)
  );

  sfax_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dest_call  (dest_call_r),
    .src_call   (src_call_r),
    .head_entry (head_entry),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
